// ----- rtl/core/krla_pkg.sv -----
// krla_pkg: codes, field widths and register reset values for the key repeat level adjuster.
// Used by rtl/core/key_repeat_level_adjuster.sv; depends on nothing.

package krla_pkg;

	// Field widths of the ports
	localparam int OP_W    = 2;
	localparam int NOW_W   = 32;
	localparam int CODE_W  = 10;
	localparam int VAL_W   = 2;
	localparam int CFG_W   = 16;
	localparam int LVL_W   = 6;
	localparam int CIDX_W  = 3;

	// Item kinds
	localparam logic [OP_W-1:0] OP_FRAME_START = 2'd0;
	localparam logic [OP_W-1:0] OP_KEY_EVENT   = 2'd1;
	localparam logic [OP_W-1:0] OP_FRAME_END   = 2'd2;

	// Key codes
	localparam logic [CODE_W-1:0] KEY_MENU   = 10'd317;
	localparam logic [CODE_W-1:0] KEY_DOWN   = 10'd310;
	localparam logic [CODE_W-1:0] KEY_UP     = 10'd311;
	localparam logic [CODE_W-1:0] KEY_SELECT = 10'd314;
	localparam logic [CODE_W-1:0] KEY_START  = 10'd315;

	// Largest key value that is still taken
	localparam logic [VAL_W-1:0] KEY_VAL_MAX = 2'd2;

	// Register indexes
	localparam logic [CIDX_W-1:0] REG_REPEAT_DELAY    = 3'd0;
	localparam logic [CIDX_W-1:0] REG_REPEAT_INTERVAL = 3'd1;
	localparam logic [CIDX_W-1:0] REG_SLEEP_GAP       = 3'd2;
	localparam logic [CIDX_W-1:0] REG_VOLUME_MAX      = 3'd3;
	localparam logic [CIDX_W-1:0] REG_BRIGHTNESS_MAX  = 3'd4;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_REPEAT_DELAY    = 16'd300;
	localparam logic [CFG_W-1:0] RST_REPEAT_INTERVAL = 16'd100;
	localparam logic [CFG_W-1:0] RST_SLEEP_GAP       = 16'd1000;
	localparam logic [LVL_W-1:0] RST_VOLUME_MAX      = 6'd20;
	localparam logic [LVL_W-1:0] RST_BRIGHTNESS_MAX  = 6'd10;

	// Input word as held in the input register
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [NOW_W-1:0]  now_ms;
		logic              is_key_event;
		logic [CODE_W-1:0] key_code;
		logic [VAL_W-1:0]  key_value;
	} in_word_t;

endpackage

// ----- rtl/core/key_repeat_level_adjuster.sv -----
// key_repeat_level_adjuster: top level, input register, state update and result register.
// Depends on krla_pkg (rtl/core/krla_pkg.sv).
//
// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_stall   op, now_ms, is_key_event, key_code, key_value
// out       source     out_valid / out_stall volume_level, brightness_level, volume_changed,
//                                            brightness_changed, combo_detected, input_ignored
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle while in_stall is low. An accepted word lands in the input
// register; from there it updates the key and level state and, for a frame end,
// loads the result register.
// Reset clears the valid flags and the block state and loads the register defaults; cfg_ready is always high.
// A frame end waiting behind a stalled full result register holds the input register,
// which raises in_stall; frame starts and key events never wait.

module key_repeat_level_adjuster
	import krla_pkg::*;
#(
	parameter int TIME_BITS  = 32,
	parameter int LEVEL_BITS = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [OP_W-1:0]   op,
	input  logic [NOW_W-1:0]  now_ms,
	input  logic              is_key_event,
	input  logic [CODE_W-1:0] key_code,
	input  logic [VAL_W-1:0]  key_value,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [LVL_W-1:0]  volume_level,
	output logic [LVL_W-1:0]  brightness_level,
	output logic              volume_changed,
	output logic              brightness_changed,
	output logic              combo_detected,
	output logic              input_ignored,
	// configuration channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int CMP_W = (LEVEL_BITS > LVL_W) ? LEVEL_BITS : LVL_W;
	localparam logic [CMP_W-1:0] LEVEL_TOP = CMP_W'({LEVEL_BITS{1'b1}});

	// Configuration registers
	logic [CFG_W-1:0] repeat_delay_q, repeat_interval_q, sleep_gap_q;
	logic [LVL_W-1:0] volume_max_q, brightness_max_q;

	// Input register
	logic     in_valid_s1;
	in_word_t in_word_s1;

	// Block state
	logic [TIME_BITS-1:0]  frame_time_q, last_frame_time_q, up_due_q, down_due_q;
	logic                  ignore_q, menu_held_q, start_held_q, select_held_q;
	logic                  up_held_q, up_fresh_q, down_held_q, down_fresh_q;
	logic [LEVEL_BITS-1:0] volume_q, brightness_q;

	// Result register
	logic                  out_valid_s2;
	logic [LVL_W-1:0]      volume_s2, brightness_s2;
	logic                  vol_chg_s2, bri_chg_s2, combo_s2, ignored_s2;

	// Handshake
	logic s1_is_end, s1_go, in_accept;

	// Next state
	logic [TIME_BITS-1:0]  frame_time_d, up_due_d, down_due_d, due_arm;
	logic                  ignore_d, menu_d, start_d, select_d;
	logic                  up_held_d, up_fresh_d, down_held_d, down_fresh_d;
	logic [LEVEL_BITS-1:0] volume_d, brightness_d;
	logic                  combo_d;
	logic [CMP_W-1:0]      vol_cap, bri_cap;
	logic                  key_take, key_on, up_step, down_step;

	// Clamp a maximum to what the level store holds
	function automatic logic [CMP_W-1:0] clamp_max(input logic [LVL_W-1:0] m);
		logic [CMP_W-1:0] w;
		w = CMP_W'(m);
		return (w > LEVEL_TOP) ? LEVEL_TOP : w;
	endfunction

	// Move one level a step, saturating at zero and at the cap
	function automatic logic [LEVEL_BITS-1:0] step_one(input logic [LEVEL_BITS-1:0] lvl,
		input logic upward, input logic [CMP_W-1:0] cap);
		logic [LEVEL_BITS-1:0] r;
		r = lvl;
		if (upward) begin
			if (CMP_W'(lvl) < cap)
				r = lvl + 1'b1;
		end else if (lvl != '0) begin
			r = lvl - 1'b1;
		end
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign s1_is_end = in_word_s1.op == OP_FRAME_END;
	assign s1_go     = in_valid_s1 && (!s1_is_end || !out_valid_s2 || !out_stall);
	assign in_stall  = in_valid_s1 && !s1_go;
	assign in_accept = in_valid && !in_stall;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_delay_q    <= RST_REPEAT_DELAY;
			repeat_interval_q <= RST_REPEAT_INTERVAL;
			sleep_gap_q       <= RST_SLEEP_GAP;
			volume_max_q      <= RST_VOLUME_MAX;
			brightness_max_q  <= RST_BRIGHTNESS_MAX;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_REPEAT_DELAY:    repeat_delay_q    <= cfg_data;
				REG_REPEAT_INTERVAL: repeat_interval_q <= cfg_data;
				REG_SLEEP_GAP:       sleep_gap_q       <= cfg_data;
				REG_VOLUME_MAX:      volume_max_q      <= cfg_data[LVL_W-1:0];
				REG_BRIGHTNESS_MAX:  brightness_max_q  <= cfg_data[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	// Load the input register; hold it while a frame end waits on the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_accept) begin
			in_valid_s1 <= 1'b1;
		end else if (s1_go) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			in_word_s1 <= '{op: op, now_ms: now_ms, is_key_event: is_key_event,
				key_code: key_code, key_value: key_value};
		end
	end

	// Work out the next state and the result for the held word
	always_comb begin
		frame_time_d = frame_time_q;
		ignore_d     = ignore_q;
		menu_d       = menu_held_q;
		start_d      = start_held_q;
		select_d     = select_held_q;
		up_held_d    = up_held_q;
		up_fresh_d   = up_fresh_q;
		up_due_d     = up_due_q;
		down_held_d  = down_held_q;
		down_fresh_d = down_fresh_q;
		down_due_d   = down_due_q;
		volume_d     = volume_q;
		brightness_d = brightness_q;
		combo_d      = 1'b0;
		up_step      = 1'b0;
		down_step    = 1'b0;
		vol_cap      = clamp_max(volume_max_q);
		bri_cap      = clamp_max(brightness_max_q);
		key_on       = in_word_s1.key_value != '0;
		key_take     = !ignore_q && in_word_s1.is_key_event &&
			(in_word_s1.key_value <= KEY_VAL_MAX);
		due_arm      = frame_time_q + TIME_BITS'(repeat_delay_q);

		case (in_word_s1.op)
			OP_FRAME_START: begin
				frame_time_d = TIME_BITS'(in_word_s1.now_ms);
				if ((frame_time_d - last_frame_time_q) > TIME_BITS'(sleep_gap_q))
					ignore_d = 1'b1;
			end
			OP_KEY_EVENT: begin
				if (key_take) begin
					case (in_word_s1.key_code)
						KEY_MENU:   menu_d = key_on;
						KEY_START:  start_d = key_on;
						KEY_SELECT: select_d = key_on;
						KEY_UP: begin
							up_held_d  = key_on;
							up_fresh_d = key_on;
							if (key_on)
								up_due_d = due_arm;
						end
						KEY_DOWN: begin
							down_held_d  = key_on;
							down_fresh_d = key_on;
							if (key_on)
								down_due_d = due_arm;
						end
						default: ;
					endcase
				end
			end
			OP_FRAME_END: begin
				// drop held navigation keys after a stale gap
				if (ignore_q) begin
					menu_d       = 1'b0;
					up_held_d    = 1'b0;
					up_fresh_d   = 1'b0;
					down_held_d  = 1'b0;
					down_fresh_d = 1'b0;
					up_due_d     = '0;
					down_due_d   = '0;
				end
				combo_d = up_held_d && down_held_d && start_d && select_d;

				// up first
				up_step = up_fresh_d || (up_held_d && (frame_time_q >= up_due_d));
				if (up_step) begin
					if (menu_d)
						brightness_d = step_one(brightness_d, 1'b1, bri_cap);
					else if (start_d)
						volume_d = step_one(volume_d, 1'b1, vol_cap);
					if (up_fresh_d)
						up_fresh_d = 1'b0;
					else
						up_due_d = up_due_d + TIME_BITS'(repeat_interval_q);
				end

				// then down, on the levels up left
				down_step = down_fresh_d || (down_held_d && (frame_time_q >= down_due_d));
				if (down_step) begin
					if (menu_d)
						brightness_d = step_one(brightness_d, 1'b0, bri_cap);
					else if (start_d)
						volume_d = step_one(volume_d, 1'b0, vol_cap);
					if (down_fresh_d)
						down_fresh_d = 1'b0;
					else
						down_due_d = down_due_d + TIME_BITS'(repeat_interval_q);
				end

				ignore_d = 1'b0;
			end
			default: ;
		endcase
	end

	// Advance the block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_time_q      <= '0;
			last_frame_time_q <= '0;
			ignore_q          <= 1'b0;
			menu_held_q       <= 1'b0;
			start_held_q      <= 1'b0;
			select_held_q     <= 1'b0;
			up_held_q         <= 1'b0;
			up_fresh_q        <= 1'b0;
			up_due_q          <= '0;
			down_held_q       <= 1'b0;
			down_fresh_q      <= 1'b0;
			down_due_q        <= '0;
			volume_q          <= '0;
			brightness_q      <= '0;
		end else if (s1_go) begin
			frame_time_q  <= frame_time_d;
			ignore_q      <= ignore_d;
			menu_held_q   <= menu_d;
			start_held_q  <= start_d;
			select_held_q <= select_d;
			up_held_q     <= up_held_d;
			up_fresh_q    <= up_fresh_d;
			up_due_q      <= up_due_d;
			down_held_q   <= down_held_d;
			down_fresh_q  <= down_fresh_d;
			down_due_q    <= down_due_d;
			volume_q      <= volume_d;
			brightness_q  <= brightness_d;
			if (s1_is_end)
				last_frame_time_q <= frame_time_q;
		end
	end

	// Result register: load on a frame end, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (s1_go && s1_is_end) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_is_end) begin
			volume_s2     <= LVL_W'(volume_d);
			brightness_s2 <= LVL_W'(brightness_d);
			vol_chg_s2    <= volume_d != volume_q;
			bri_chg_s2    <= brightness_d != brightness_q;
			combo_s2      <= combo_d;
			ignored_s2    <= ignore_q;
		end
	end

	assign out_valid          = out_valid_s2;
	assign volume_level       = volume_s2;
	assign brightness_level   = brightness_s2;
	assign volume_changed     = vol_chg_s2;
	assign brightness_changed = bri_chg_s2;
	assign combo_detected     = combo_s2;
	assign input_ignored      = ignored_s2;

	// A frame end steps only one of the two levels
	a_one_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> !(vol_chg_s2 && bri_chg_s2))
		else $error("both levels changed in one frame");

	// The input side stalls only behind a full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (in_valid_s1 && s1_is_end && out_valid_s2))
		else $error("input stalled without a waiting frame end");

	// A frame end always clears the stale flag
	a_ignore_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && s1_is_end) |=> !ignore_q)
		else $error("stale flag survived a frame end");

	// A stale frame end releases menu and both fresh presses
	a_stale_release: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && s1_is_end && ignore_q) |=> (!menu_held_q && !up_fresh_q && !down_fresh_q))
		else $error("keys still held after a stale frame");

endmodule

// ----- dv/tb.sv -----
// tb: self-checking bench for key_repeat_level_adjuster. Drives frame start, key event,
// frame end and unused-op words, predicts each frame report and compares it field by field.
// Depends on krla_pkg (rtl/core/krla_pkg.sv) and the block RTL.

module tb;
	import krla_pkg::*;

	localparam int TIMEOUT      = 6_000_000;
	localparam int DRAIN_CYCLES = 4;

	localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
	localparam logic [VAL_W-1:0]  VAL_RELEASE = 2'd0;
	localparam logic [VAL_W-1:0]  VAL_PRESS   = 2'd1;
	localparam logic [VAL_W-1:0]  VAL_REPEAT  = 2'd2;
	localparam logic [VAL_W-1:0]  VAL_OTHER   = 2'd3;
	localparam logic [CIDX_W-1:0] REG_NONE    = 3'd7;

	typedef struct packed {
		logic [LVL_W-1:0] volume;
		logic [LVL_W-1:0] brightness;
		logic             vol_chg;
		logic             bri_chg;
		logic             combo;
		logic             ignored;
	} level_report_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic [OP_W-1:0]   op           = '0;
	logic [NOW_W-1:0]  now_ms       = '0;
	logic              is_key_event = 1'b0;
	logic [CODE_W-1:0] key_code     = '0;
	logic [VAL_W-1:0]  key_value    = '0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic [LVL_W-1:0]  volume_level;
	logic [LVL_W-1:0]  brightness_level;
	logic              volume_changed;
	logic              brightness_changed;
	logic              combo_detected;
	logic              input_ignored;
	logic              cfg_valid    = 1'b0;
	logic              cfg_ready;
	logic [CIDX_W-1:0] cfg_index    = '0;
	logic [CFG_W-1:0]  cfg_data     = '0;

	// Predicted block state, starting from its reset values
	logic [CFG_W-1:0] delay_cfg    = RST_REPEAT_DELAY;
	logic [CFG_W-1:0] interval_cfg = RST_REPEAT_INTERVAL;
	logic [CFG_W-1:0] gap_cfg      = RST_SLEEP_GAP;
	logic [LVL_W-1:0] vol_cap      = RST_VOLUME_MAX;
	logic [LVL_W-1:0] bri_cap      = RST_BRIGHTNESS_MAX;
	logic [NOW_W-1:0] cur_ms       = '0;
	logic [NOW_W-1:0] prev_ms      = '0;
	logic [NOW_W-1:0] up_next_ms   = '0;
	logic [NOW_W-1:0] down_next_ms = '0;
	logic             stale        = 1'b0;
	logic             menu_dn      = 1'b0;
	logic             start_dn     = 1'b0;
	logic             select_dn    = 1'b0;
	logic             up_dn        = 1'b0;
	logic             up_new       = 1'b0;
	logic             down_dn      = 1'b0;
	logic             down_new     = 1'b0;
	logic [LVL_W-1:0] vol_lvl      = '0;
	logic [LVL_W-1:0] bri_lvl      = '0;

	level_report_t    level_q[$];
	int               fail_count = 0;
	logic [NOW_W-1:0] sim_ms     = '0;
	bit               idle_on    = 1'b0;
	bit               stall_on   = 1'b0;
	int               stall_left = 0;

	key_repeat_level_adjuster dut (.*);

	always #5 clk = ~clk;

	// Mostly no pause, sometimes a short one, rarely a long one
	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [CODE_W-1:0] pick_code();
		case ($urandom_range(0, 11))
			0, 1, 2: return KEY_UP;
			3, 4, 5: return KEY_DOWN;
			6, 7:    return KEY_START;
			8:       return KEY_MENU;
			9:       return KEY_SELECT;
			default: return CODE_W'($urandom);
		endcase
	endfunction

	// Step brightness while menu is held, else volume while start is held
	function automatic void nudge_level(input logic upward);
		if (menu_dn) begin
			if (upward) begin
				if (bri_lvl < bri_cap) bri_lvl++;
			end else if (bri_lvl != '0) begin
				bri_lvl--;
			end
		end else if (start_dn) begin
			if (upward) begin
				if (vol_lvl < vol_cap) vol_lvl++;
			end else if (vol_lvl != '0) begin
				vol_lvl--;
			end
		end
	endfunction

	// Fresh press steps once; a held key steps and re-arms when its time has come
	function automatic void serve_repeat(inout logic held, inout logic fresh,
			inout logic [NOW_W-1:0] next_ms, input logic upward);
		if (fresh || (held && cur_ms >= next_ms)) begin
			nudge_level(upward);
			if (fresh) fresh = 1'b0;
			else next_ms = next_ms + NOW_W'(interval_cfg);
		end
	endfunction

	// Advance the predicted state by one accepted word; queue a report on frame end
	function automatic void predict_levels(input in_word_t w);
		logic [NOW_W-1:0] since;
		logic [LVL_W-1:0] vol0, bri0;
		logic             pressed, combo;
		level_report_t    rep;
		case (w.op)
			OP_FRAME_START: begin
				cur_ms = w.now_ms;
				since = cur_ms - prev_ms;
				if (since > NOW_W'(gap_cfg)) stale = 1'b1;
			end
			OP_KEY_EVENT: begin
				pressed = w.key_value != VAL_RELEASE;
				if (!stale && w.is_key_event && w.key_value <= KEY_VAL_MAX) begin
					case (w.key_code)
						KEY_MENU:   menu_dn = pressed;
						KEY_START:  start_dn = pressed;
						KEY_SELECT: select_dn = pressed;
						KEY_DOWN: begin
							down_dn = pressed;
							down_new = pressed;
							if (pressed) down_next_ms = cur_ms + NOW_W'(delay_cfg);
						end
						KEY_UP: begin
							up_dn = pressed;
							up_new = pressed;
							if (pressed) up_next_ms = cur_ms + NOW_W'(delay_cfg);
						end
						default: ;
					endcase
				end
			end
			OP_FRAME_END: begin
				vol0 = vol_lvl;
				bri0 = bri_lvl;
				rep.ignored = stale;
				if (stale) begin
					menu_dn = 1'b0;
					up_dn = 1'b0;
					up_new = 1'b0;
					down_dn = 1'b0;
					down_new = 1'b0;
					up_next_ms = '0;
					down_next_ms = '0;
				end
				combo = up_dn && down_dn && start_dn && select_dn;
				serve_repeat(up_dn, up_new, up_next_ms, 1'b1);
				serve_repeat(down_dn, down_new, down_next_ms, 1'b0);
				prev_ms = cur_ms;
				stale = 1'b0;
				rep.volume = vol_lvl;
				rep.brightness = bri_lvl;
				rep.vol_chg = vol_lvl != vol0;
				rep.bri_chg = bri_lvl != bri0;
				rep.combo = combo;
				level_q.push_back(rep);
			end
			default: ;
		endcase
	endfunction

	function automatic void track_reg_write(input logic [CIDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		case (idx)
			REG_REPEAT_DELAY:    delay_cfg = data;
			REG_REPEAT_INTERVAL: interval_cfg = data;
			REG_SLEEP_GAP:       gap_cfg = data;
			REG_VOLUME_MAX:      vol_cap = data[LVL_W-1:0];
			REG_BRIGHTNESS_MAX:  bri_cap = data[LVL_W-1:0];
			default: ;
		endcase
	endfunction

	// Present one word, hold it until taken, then update the prediction
	task automatic send_item(input logic [OP_W-1:0] op_v, input logic [NOW_W-1:0] now_v,
			input logic isk_v, input logic [CODE_W-1:0] code_v, input logic [VAL_W-1:0] val_v);
		in_word_t w;
		int       gap;
		w.op = op_v;
		w.now_ms = now_v;
		w.is_key_event = isk_v;
		w.key_code = code_v;
		w.key_value = val_v;
		gap = idle_on ? pick_pause() : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= op_v;
		now_ms <= now_v;
		is_key_event <= isk_v;
		key_code <= code_v;
		key_value <= val_v;
		do @(posedge clk); while (in_stall);
		predict_levels(w);
	endtask

	// Drop valid and wait until every predicted report has come out
	task automatic wait_drained(input int settle);
		@(negedge clk);
		in_valid <= 1'b0;
		while (level_q.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		track_reg_write(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_regs(input logic [CFG_W-1:0] delay_v, input logic [CFG_W-1:0] ivl_v,
			input logic [CFG_W-1:0] gap_v, input logic [CFG_W-1:0] vmax_v,
			input logic [CFG_W-1:0] bmax_v);
		wait_drained(DRAIN_CYCLES);
		write_reg(REG_REPEAT_DELAY, delay_v);
		write_reg(REG_REPEAT_INTERVAL, ivl_v);
		write_reg(REG_SLEEP_GAP, gap_v);
		write_reg(REG_VOLUME_MAX, vmax_v);
		write_reg(REG_BRIGHTNESS_MAX, bmax_v);
	endtask

	// One frame per iteration: frame start, a press of the given key, frame end
	task automatic press_frames(input logic [CODE_W-1:0] code, input int n);
		repeat (n) begin
			sim_ms = sim_ms + 1;
			send_item(OP_FRAME_START, sim_ms, 1'($urandom), CODE_W'($urandom),
				VAL_W'($urandom));
			send_item(OP_KEY_EVENT, $urandom, 1'b1, code, VAL_PRESS);
			send_item(OP_FRAME_END, $urandom, 1'($urandom), CODE_W'($urandom),
				VAL_W'($urandom));
		end
	endtask

	// Random frames with random key traffic, noise words and broken frames
	task automatic run_frames(input int frames, input int step_max);
		int               r;
		logic [NOW_W-1:0] adv;
		for (int f = 0; f < frames; f++) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				send_item(OP_UNUSED, $urandom, 1'($urandom), CODE_W'($urandom),
					VAL_W'($urandom));
			else if (r == 1)
				send_item(OP_KEY_EVENT, $urandom, 1'b0, pick_code(), VAL_W'($urandom));
			else if (r == 2)
				send_item(OP_KEY_EVENT, $urandom, 1'b1, pick_code(), VAL_OTHER);
			else if (r == 3)
				send_item(OP_KEY_EVENT, $urandom, 1'b1, CODE_W'($urandom),
					VAL_W'($urandom_range(0, 2)));

			// advance time: small steps, steps around the stale gap, wild jumps, or none
			r = $urandom_range(0, 99);
			if (r < 75) adv = $urandom_range(0, step_max);
			else if (r < 88) adv = NOW_W'(gap_cfg) + NOW_W'($urandom_range(0, 2)) - 1;
			else adv = $urandom;
			if (r < 94) begin
				sim_ms = sim_ms + adv;
				send_item(OP_FRAME_START, sim_ms, 1'($urandom), CODE_W'($urandom),
					VAL_W'($urandom));
				if ($urandom_range(0, 14) == 0) begin
					sim_ms = sim_ms + $urandom_range(0, 50);
					send_item(OP_FRAME_START, sim_ms, 1'($urandom), CODE_W'($urandom),
						VAL_W'($urandom));
				end
			end

			repeat ($urandom_range(0, 3))
				send_item(OP_KEY_EVENT, $urandom, 1'b1, pick_code(),
					VAL_W'($urandom_range(0, 2)));
			send_item(OP_FRAME_END, $urandom, 1'($urandom), CODE_W'($urandom),
				VAL_W'($urandom));

			// hold the sender now and then until all reports are out
			if ($urandom_range(0, 39) == 0) wait_drained(0);
		end
	endtask

	task automatic test_directed();
		idle_on = 1'b1;
		stall_on = 1'b1;
		send_item(OP_FRAME_END, '0, 1'b0, '0, VAL_RELEASE);
		send_item(OP_UNUSED, '1, 1'b1, '1, VAL_OTHER);
		send_item(OP_FRAME_START, '0, 1'b0, '0, VAL_RELEASE);
		send_item(OP_KEY_EVENT, '0, 1'b1, KEY_START, VAL_PRESS);
		// dropped: not a key event, value out of range, unknown code
		send_item(OP_KEY_EVENT, '1, 1'b0, KEY_UP, VAL_PRESS);
		send_item(OP_KEY_EVENT, '0, 1'b1, KEY_DOWN, VAL_OTHER);
		send_item(OP_KEY_EVENT, '0, 1'b1, '1, VAL_PRESS);
		send_item(OP_KEY_EVENT, '0, 1'b1, KEY_UP, VAL_PRESS);
		send_item(OP_FRAME_END, '0, 1'b0, '0, VAL_RELEASE);
		// up still held past its delay
		send_item(OP_FRAME_START, 32'd350, 1'b0, '0, VAL_RELEASE);
		send_item(OP_FRAME_END, '0, 1'b0, '0, VAL_RELEASE);
		// menu held by a repeat value, all four combo keys down, brightness wins
		send_item(OP_KEY_EVENT, '0, 1'b1, KEY_MENU, VAL_REPEAT);
		send_item(OP_KEY_EVENT, '0, 1'b1, KEY_DOWN, VAL_PRESS);
		send_item(OP_KEY_EVENT, '0, 1'b1, KEY_SELECT, VAL_PRESS);
		send_item(OP_FRAME_START, 32'd360, 1'b0, '0, VAL_RELEASE);
		send_item(OP_FRAME_END, '0, 1'b0, '0, VAL_RELEASE);
		// stale gap, repeated frame start, key dropped while stale
		send_item(OP_FRAME_START, 32'd5000, 1'b0, '0, VAL_RELEASE);
		send_item(OP_FRAME_START, 32'd5001, 1'b0, '0, VAL_RELEASE);
		send_item(OP_KEY_EVENT, '0, 1'b1, KEY_START, VAL_RELEASE);
		send_item(OP_FRAME_END, '0, 1'b0, '0, VAL_RELEASE);
		// top of the time range, then wrap back past zero
		send_item(OP_FRAME_START, '1, 1'b1, '1, VAL_OTHER);
		send_item(OP_FRAME_END, '1, 1'b1, '1, VAL_OTHER);
		send_item(OP_FRAME_START, 32'd5, 1'b0, '0, VAL_RELEASE);
		send_item(OP_FRAME_END, '0, 1'b0, '0, VAL_RELEASE);
		sim_ms = 32'd5;
	endtask

	task automatic test_lowered_max();
		idle_on = 1'b0;
		stall_on = 1'b1;
		program_regs(RST_REPEAT_DELAY, RST_REPEAT_INTERVAL, RST_SLEEP_GAP, '1, '1);
		send_item(OP_KEY_EVENT, $urandom, 1'b1, KEY_START, VAL_PRESS);
		send_item(OP_KEY_EVENT, $urandom, 1'b1, KEY_MENU, VAL_RELEASE);
		press_frames(KEY_UP, 30);
		send_item(OP_KEY_EVENT, $urandom, 1'b1, KEY_MENU, VAL_PRESS);
		press_frames(KEY_UP, 12);
		// lower both maxima below the current levels
		wait_drained(DRAIN_CYCLES);
		write_reg(REG_VOLUME_MAX, CFG_W'(5));
		write_reg(REG_BRIGHTNESS_MAX, CFG_W'(4));
		press_frames(KEY_UP, 2);
		press_frames(KEY_DOWN, 3);
		send_item(OP_KEY_EVENT, $urandom, 1'b1, KEY_MENU, VAL_RELEASE);
		press_frames(KEY_UP, 2);
		press_frames(KEY_DOWN, 3);
	endtask

	task automatic test_register_sweep();
		for (int k = 0; k < 6; k++) begin
			case (k)
				0: program_regs('0, '0, '0, '0, '0);
				1: program_regs('1, '1, '1, '1, '1);
				2: begin
					program_regs(CFG_W'($urandom_range(0, 50)), CFG_W'($urandom_range(0, 20)),
						CFG_W'($urandom_range(100, 400)), CFG_W'($urandom_range(0, 63)),
						CFG_W'($urandom_range(0, 63)));
					write_reg(REG_NONE, CFG_W'($urandom));
				end
				3: program_regs(RST_REPEAT_DELAY, RST_REPEAT_INTERVAL, RST_SLEEP_GAP,
					CFG_W'(RST_VOLUME_MAX), CFG_W'(RST_BRIGHTNESS_MAX));
				4: program_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
					CFG_W'($urandom), CFG_W'($urandom));
				default: program_regs('1, '0, '1, CFG_W'(1), CFG_W'(1));
			endcase
			idle_on = k[0];
			stall_on = k[1];
			run_frames(35, 150);
		end
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < 8; p++) begin
			program_regs(CFG_W'($urandom_range(0, 400)), CFG_W'($urandom_range(0, 150)),
				CFG_W'($urandom_range(50, 2000)), CFG_W'($urandom_range(0, 63)),
				CFG_W'($urandom_range(0, 63)));
			// cross the top of the time range in some phases
			if (p % 3 == 2) sim_ms = '1 - NOW_W'($urandom_range(0, 2000));
			idle_on = 1'($urandom);
			stall_on = 1'($urandom);
			run_frames(30, $urandom_range(20, 300));
		end
	endtask

	// Hold the report channel off in random bursts
	always @(negedge clk) begin : stall_gen
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			if (stall_on) stall_left = pick_pause();
		end
	end

	task automatic check_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
			fail_count++;
		end
	endtask

	// Compare each report word against the oldest prediction
	always @(posedge clk) begin : report_check
		level_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (level_q.size() == 0) begin
				$display("%0t: report with none expected: volume %0d brightness %0d",
					$time, volume_level, brightness_level);
				fail_count++;
			end else begin
				want = level_q.pop_front();
				check_field("volume_level", int'(want.volume), int'(volume_level));
				check_field("brightness_level", int'(want.brightness), int'(brightness_level));
				check_field("volume_changed", int'(want.vol_chg), int'(volume_changed));
				check_field("brightness_changed", int'(want.bri_chg),
					int'(brightness_changed));
				check_field("combo_detected", int'(want.combo), int'(combo_detected));
				check_field("input_ignored", int'(want.ignored), int'(input_ignored));
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_lowered_max();
		test_register_sweep();
		test_random_phases();
		wait_drained(10);
		if (fail_count == 0) $display("tb: PASS");
		else $display("tb: FAIL");
		$finish;
	end

	initial begin
		#(TIMEOUT);
		$display("tb: FAIL");
		$finish;
	end

endmodule
